[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// The SYNTH build gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[hdl/csvt_pkg.sv]
package csvt_pkg;

  localparam int DEF_BLANK_BUFFER_DEPTH = 32;
  localparam int DEF_COLUMN_LIMIT       = 1024;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 6;
  localparam int FIELD_W = 10;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Configuration register indexes
  localparam logic [1:0] REG_SEPARATOR = 2'd0;
  localparam logic [1:0] REG_QUOTE     = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_END_FIELD = 2'd1;
  localparam logic [1:0] KIND_END_REC   = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OPEN_QUOTE = 3'd1;
  localparam logic [2:0] ERR_AFTER_QUOTE = 3'd2;
  localparam logic [2:0] ERR_BAD_CONFIG = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [BYTE_W-1:0]  data;
    logic [2:0]         code;
    logic [FIELD_W-1:0] field;
  } tok_t;

  // Source of the next result loaded into the output register
  typedef enum logic [1:0] {
    SEL_NOW0,
    SEL_BLANK,
    SEL_TAIL0,
    SEL_TAIL1
  } sel_t;

  typedef struct packed {
    logic accept;
    logic load;
    sel_t sel;
    logic last;
    logic blank_adv;
  } cmd_t;

  typedef struct packed {
    logic       plan_flush;
    logic [1:0] plan_ntail;
    logic [1:0] tail_n;
    logic       blank_pending;
    logic       blank_last;
  } stat_t;

  function automatic tok_t make_tok(input logic [1:0] kind, input logic [BYTE_W-1:0] data,
                                    input logic [2:0] code, input logic [FIELD_W-1:0] field);
    tok_t t;
    t.kind  = kind;
    t.data  = data;
    t.code  = code;
    t.field = field;
    return t;
  endfunction

endpackage

[hdl/csv_stream_tokenizer_top.sv]
// Without held blanks to flush, the first result of a byte is shown in the output register the cycle after
// the byte transfers; held blanks flushed ahead of a byte are read from the blank buffer and shown first,
// each once the output register is free, and the byte's own results follow. A new byte is taken only once
// every result of the last one has been loaded and the output register is free.
// Reset (rst_n, synchronous, active low) clears parse state and the error latch and
// loads comma and double quote into the config registers; the blank buffer is not cleared.
module csv_stream_tokenizer_top #(
  parameter int BLANK_BUFFER_DEPTH = csvt_pkg::DEF_BLANK_BUFFER_DEPTH,
  parameter int COLUMN_LIMIT       = csvt_pkg::DEF_COLUMN_LIMIT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write_en,
  input  logic [1:0]                   cfg_index,
  input  logic [csvt_pkg::BYTE_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [csvt_pkg::BYTE_W-1:0]  in_text_byte,
  input  logic                         in_end_of_text,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [csvt_pkg::BYTE_W-1:0]  out_out_byte,
  output logic [2:0]                   out_error_code,
  output logic [csvt_pkg::FIELD_W-1:0] out_field_index,
  output logic                         out_last_in_run
);

  import csvt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  csvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csvt_dp #(
    .BLANK_BUFFER_DEPTH(BLANK_BUFFER_DEPTH),
    .COLUMN_LIMIT      (COLUMN_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cmd            (cmd),
    .stat           (stat),
    .out_kind       (out_kind),
    .out_out_byte   (out_out_byte),
    .out_error_code (out_error_code),
    .out_field_index(out_field_index),
    .out_last_in_run(out_last_in_run)
  );

endmodule

[hdl/csvt_ram.sv]
module csvt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/csvt_ctrl.sv]
`include "assert_macros.svh"

module csvt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  csvt_pkg::stat_t stat,
  output csvt_pkg::cmd_t  cmd
);

  import csvt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLANK,
    S_TAIL0,
    S_TAIL1
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.load      = 1'b0;
    cmd.sel       = SEL_NOW0;
    cmd.last      = 1'b0;
    cmd.blank_adv = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.accept = 1'b1;
          if (stat.plan_flush) begin
            state_nxt = S_BLANK;
          end else if (stat.plan_ntail != 2'd0) begin
            // first result goes straight to the output register
            cmd.load = 1'b1;
            cmd.sel  = SEL_NOW0;
            cmd.last = (stat.plan_ntail == 2'd1);
            if (stat.plan_ntail == 2'd2) begin
              state_nxt = S_TAIL1;
            end
          end
        end
      end
      S_BLANK: begin
        if (out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_BLANK;
          if (!stat.blank_last) begin
            cmd.blank_adv = 1'b1;
          end else begin
            cmd.last  = (stat.tail_n == 2'd0);
            state_nxt = (stat.tail_n == 2'd0) ? S_IDLE : S_TAIL0;
          end
        end
      end
      S_TAIL0: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_TAIL0;
          cmd.last  = (stat.tail_n == 2'd1);
          state_nxt = (stat.tail_n == 2'd2) ? S_TAIL1 : S_IDLE;
        end
      end
      S_TAIL1: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_TAIL1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_PROP(a_flush_enters_blank, clk, rst_n, (cmd.accept && stat.plan_flush) |=> (state_r == S_BLANK), "flush plan did not start the blank sweep")
  `ASSERT_PROP(a_blank_has_work, clk, rst_n, (state_r == S_BLANK) |-> stat.blank_pending, "blank sweep with an empty buffer")
  `ASSERT_PROP(a_pair_shows_first, clk, rst_n, (cmd.accept && !stat.plan_flush && stat.plan_ntail == 2'd2) |=> (out_valid_r && state_r == S_TAIL1), "first of two results not shown")

endmodule

[hdl/csvt_dp.sv]
`include "assert_macros.svh"

module csvt_dp #(
  parameter int BLANK_BUFFER_DEPTH = csvt_pkg::DEF_BLANK_BUFFER_DEPTH,
  parameter int COLUMN_LIMIT       = csvt_pkg::DEF_COLUMN_LIMIT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [1:0]                    cfg_index,
  input  logic [csvt_pkg::BYTE_W-1:0]   cfg_data,
  input  logic [csvt_pkg::BYTE_W-1:0]   in_text_byte,
  input  logic                          in_end_of_text,
  input  csvt_pkg::cmd_t                cmd,
  output csvt_pkg::stat_t               stat,
  output logic [1:0]                    out_kind,
  output logic [csvt_pkg::BYTE_W-1:0]   out_out_byte,
  output logic [2:0]                    out_error_code,
  output logic [csvt_pkg::FIELD_W-1:0]  out_field_index,
  output logic                          out_last_in_run
);

  import csvt_pkg::*;

  localparam int AW = (BLANK_BUFFER_DEPTH > 1) ? $clog2(BLANK_BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(COLUMN_LIMIT);

  typedef enum logic [2:0] {
    M_START,
    M_UNQ,
    M_QUO,
    M_QUOQ,
    M_AFTER
  } mode_t;

  typedef enum logic [1:0] {
    BRK_NONE,
    BRK_CR,
    BRK_LF
  } brk_t;

  logic [BYTE_W-1:0] sep_r, quote_r;
  mode_t             mode_r, mode_nxt;
  brk_t              brk_r, brk_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              err_r, err_nxt;

  // per-byte plan, applied on transfer
  tok_t              plan_tok [2];
  logic [1:0]        plan_ntail;
  logic [CNT_W-1:0]  plan_nblank;
  logic              wr_en, wr_tab;

  tok_t              tail_r [2];
  logic [1:0]        ntail_r;
  logic [CNT_W-1:0]  nblank_r, idx_r;
  logic [CNT_W-1:0]  idx_inc;

  logic              ram_re, ram_rdata;
  logic [AW-1:0]     ram_raddr;

  logic [1:0]         kind_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [2:0]         code_r;
  logic [FIELD_W-1:0] field_r;
  logic               last_r;
  tok_t               sel_tok;

  always_comb begin
    logic [BYTE_W-1:0] c;
    logic              eot, is_blank, is_break, is_sep, is_quote;
    logic              f_err, f_byte, f_sep, f_end, f_aq, skip;
    logic [2:0]        ecode;
    logic [CW-1:0]     col_cur;
    logic [1:0]        ntl;

    c        = in_text_byte;
    eot      = in_end_of_text;
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
    is_break = (c == CH_CR) || (c == CH_LF);
    is_sep   = (c == sep_r);
    is_quote = (c == quote_r);

    mode_nxt = mode_r;
    brk_nxt  = brk_r;
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    err_nxt  = err_r;
    f_err    = 1'b0;
    f_byte   = 1'b0;
    f_sep    = 1'b0;
    f_end    = 1'b0;
    f_aq     = 1'b0;
    skip     = 1'b0;
    ecode    = ERR_NONE;
    wr_en    = 1'b0;
    wr_tab   = (c == CH_TAB);
    plan_nblank = '0;
    plan_ntail  = 2'd0;
    plan_tok[0] = make_tok(KIND_BYTE, 8'h00, ERR_NONE, '0);
    plan_tok[1] = make_tok(KIND_BYTE, 8'h00, ERR_NONE, '0);
    ntl         = 2'd0;
    col_cur     = col_r;

    if (!err_r) begin
      if (sep_r == 8'h00 || quote_r == 8'h00 || sep_r == quote_r) begin
        f_err = 1'b1;
        ecode = ERR_BAD_CONFIG;
      end else begin
        // drop the second half of a CR LF or LF CR pair
        if (brk_r != BRK_NONE) begin
          brk_nxt = BRK_NONE;
          if (mode_r == M_START &&
              ((brk_r == BRK_CR && c == CH_LF) || (brk_r == BRK_LF && c == CH_CR))) begin
            skip = 1'b1;
          end
        end
        if (!skip) begin
          case (mode_r)
            M_START: begin
              if (is_blank) begin
                f_end = eot;
              end else if (is_break) begin
                f_end   = 1'b1;
                brk_nxt = (c == CH_CR) ? BRK_CR : BRK_LF;
              end else if (is_quote) begin
                if (eot) begin
                  f_err = 1'b1;
                  ecode = ERR_OPEN_QUOTE;
                end else begin
                  mode_nxt = M_QUO;
                end
              end else if (is_sep) begin
                f_sep = 1'b1;
                f_end = eot;
              end else begin
                f_byte   = 1'b1;
                mode_nxt = M_UNQ;
                f_end    = eot;
              end
            end
            M_UNQ: begin
              if (is_sep) begin
                cnt_nxt  = '0;
                f_sep    = 1'b1;
                f_end    = eot;
                mode_nxt = M_START;
              end else if (is_break) begin
                cnt_nxt  = '0;
                f_end    = 1'b1;
                brk_nxt  = (c == CH_CR) ? BRK_CR : BRK_LF;
                mode_nxt = M_START;
              end else if (is_blank) begin
                if (cnt_r >= CNT_W'(BLANK_BUFFER_DEPTH)) begin
                  f_err = 1'b1;
                  ecode = ERR_OVERFLOW;
                end else begin
                  wr_en   = 1'b1;
                  cnt_nxt = cnt_r + CNT_W'(1);
                  f_end   = eot;
                end
              end else begin
                plan_nblank = cnt_r;
                cnt_nxt     = '0;
                f_byte      = 1'b1;
                f_end       = eot;
              end
            end
            M_QUO: begin
              if (is_quote) begin
                mode_nxt = M_QUOQ;
                f_end    = eot;
              end else if (eot) begin
                f_err = 1'b1;
                ecode = ERR_OPEN_QUOTE;
              end else begin
                f_byte = 1'b1;
              end
            end
            M_QUOQ: begin
              if (is_quote) begin
                if (eot) begin
                  f_err = 1'b1;
                  ecode = ERR_OPEN_QUOTE;
                end else begin
                  mode_nxt = M_QUO;
                  f_byte   = 1'b1;
                end
              end else begin
                f_aq = 1'b1;
              end
            end
            default: begin
              f_aq = 1'b1;
            end
          endcase
          if (f_aq) begin
            mode_nxt = M_AFTER;
            if (is_blank) begin
              f_end = eot;
            end else if (is_sep) begin
              f_sep    = 1'b1;
              f_end    = eot;
              mode_nxt = M_START;
            end else if (is_break) begin
              f_end    = 1'b1;
              brk_nxt  = (c == CH_CR) ? BRK_CR : BRK_LF;
              mode_nxt = M_START;
            end else begin
              f_err = 1'b1;
              ecode = ERR_AFTER_QUOTE;
            end
          end
        end
      end
    end

    // build the results in emission order
    if (f_err) begin
      plan_tok[ntl[0]] = make_tok(KIND_ERROR, 8'h00, ecode, FIELD_W'(col_cur));
      ntl     = ntl + 2'd1;
      err_nxt = 1'b1;
    end
    if (f_byte) begin
      plan_tok[ntl[0]] = make_tok(KIND_BYTE, c, ERR_NONE, FIELD_W'(col_cur));
      ntl = ntl + 2'd1;
    end
    if (f_sep) begin
      plan_tok[ntl[0]] = make_tok(KIND_END_FIELD, 8'h00, ERR_NONE, FIELD_W'(col_cur));
      ntl = ntl + 2'd1;
      if (col_cur != CW'(COLUMN_LIMIT - 1)) begin
        col_cur = col_cur + CW'(1);
      end
      col_nxt = col_cur;
    end
    if (f_end) begin
      plan_tok[ntl[0]] = make_tok(KIND_END_REC, 8'h00, ERR_NONE, FIELD_W'(col_cur));
      ntl     = ntl + 2'd1;
      col_nxt = '0;
    end
    plan_ntail = ntl;

    // end of text returns the parser to its reset state
    if (eot) begin
      mode_nxt = M_START;
      brk_nxt  = BRK_NONE;
      cnt_nxt  = '0;
      col_nxt  = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= CH_COMMA;
      quote_r <= CH_QUOTE;
      mode_r  <= M_START;
      brk_r   <= BRK_NONE;
      cnt_r   <= '0;
      col_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_write_en && cfg_index == REG_SEPARATOR) begin
        sep_r <= cfg_data;
      end
      if (cfg_write_en && cfg_index == REG_QUOTE) begin
        quote_r <= cfg_data;
      end
      if (cmd.accept) begin
        mode_r <= mode_nxt;
        brk_r  <= brk_nxt;
        cnt_r  <= cnt_nxt;
        col_r  <= col_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // plan storage for the multi-cycle results
  assign idx_inc = idx_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntail_r  <= 2'd0;
      nblank_r <= '0;
      idx_r    <= '0;
    end else if (cmd.accept) begin
      ntail_r  <= plan_ntail;
      nblank_r <= plan_nblank;
      idx_r    <= '0;
    end else if (cmd.blank_adv) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tail_r[0] <= plan_tok[0];
      tail_r[1] <= plan_tok[1];
    end
  end

  assign ram_re    = cmd.accept || cmd.blank_adv;
  assign ram_raddr = cmd.accept ? '0 : idx_inc[AW-1:0];

  csvt_ram #(
    .WIDTH(1),
    .DEPTH(BLANK_BUFFER_DEPTH)
  ) u_blank_ram (
    .clk  (clk),
    .we   (cmd.accept && wr_en),
    .waddr(cnt_r[AW-1:0]),
    .wdata(wr_tab),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stat.plan_flush    = (plan_nblank != '0);
  assign stat.plan_ntail    = plan_ntail;
  assign stat.tail_n        = ntail_r;
  assign stat.blank_pending = (nblank_r != '0);
  assign stat.blank_last    = (idx_r == nblank_r - CNT_W'(1));

  always_comb begin
    case (cmd.sel)
      SEL_NOW0:  sel_tok = plan_tok[0];
      SEL_BLANK: sel_tok = make_tok(KIND_BYTE, ram_rdata ? CH_TAB : CH_SPACE, ERR_NONE,
                                    tail_r[0].field);
      SEL_TAIL0: sel_tok = tail_r[0];
      SEL_TAIL1: sel_tok = tail_r[1];
      default:   sel_tok = tail_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= sel_tok.kind;
      byte_r  <= sel_tok.data;
      code_r  <= sel_tok.code;
      field_r <= sel_tok.field;
      last_r  <= cmd.last;
    end
  end

  assign out_kind        = kind_r;
  assign out_out_byte    = byte_r;
  assign out_error_code  = code_r;
  assign out_field_index = field_r;
  assign out_last_in_run = last_r;

  `ASSERT_PROP(a_blank_count_bound, clk, rst_n, cnt_r <= CNT_W'(BLANK_BUFFER_DEPTH), "blank count beyond buffer depth")
  `ASSERT_PROP(a_column_bound, clk, rst_n, col_r <= CW'(COLUMN_LIMIT - 1), "column position beyond limit")
  `ASSERT_PROP(a_sweep_index_bound, clk, rst_n, (nblank_r == '0) || (idx_r < nblank_r), "blank sweep index past held count")

endmodule
